FILE: rtl/core/ffa_pkg.sv
// Package for the first-fit block allocator: types, constants and the heap reset image.
package ffa_pkg;

    localparam int HEAP_CHUNKS = 256;
    localparam int ADDR_W      = $clog2(HEAP_CHUNKS);
    localparam int SIZE_W      = 8;
    localparam int ENTRY_W     = SIZE_W + 1;
    localparam int WALK_W      = ADDR_W + 1;

    localparam logic [WALK_W-1:0] HEAP_END = WALK_W'(HEAP_CHUNKS);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] req_size;
        logic [SIZE_W-1:0] block_index;
    } t_ffa_in;

    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] block_start;
    } t_ffa_out;

    // header entry: size in the upper bits, allocated flag in bit 0
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              used;
    } t_ffa_hdr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_FREE
    } t_ffa_state;

    function automatic t_ffa_hdr ffa_reset_hdr(input logic [ADDR_W-1:0] addr);
        t_ffa_hdr h;
        h.size = '0;
        h.used = 1'b0;
        if (addr == '0) begin
            h.size = SIZE_W'(HEAP_CHUNKS - 2);
        end else if (addr == ADDR_W'(HEAP_CHUNKS - 1)) begin
            h.used = 1'b1;
        end
        return h;
    endfunction

endpackage

FILE: rtl/core/ffa_ram.sv
// Generic single-port RAM with registered read data.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/first_fit_block_allocator.sv
// First-fit block allocator over an implicit list of block headers.
//
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. kind selects allocate (req_size) or free (block_index).
// Result channel: o_done strobes for one cycle with o_result; the receiver
// cannot hold it off, and a new command may be started in that same cycle.
// Sequence: a free reads the header, then writes it back with the
// allocated flag cleared. An allocate with size zero strobes in the cycle
// after the start. Any other allocate reads one header per cycle from the
// header RAM (one port, registered read), walking headers up to and
// including the fitting or final one; when the block is larger than asked,
// a split then writes the remainder header.
// Worst case is HEAP_CHUNKS - 1 headers walked: a one-chunk free remainder is a
// header of its own, so every chunk after the first payload chunk can be one.
// Reset: the header RAM is not cleared; a valid flag per chunk, cleared by
// reset, makes an unwritten chunk read as the initial layout (one free block
// at chunk 0 and the terminator in the last chunk). No clearing pass.
module first_fit_block_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ffa_pkg::t_ffa_in  i_cmd,
    output logic              o_done,
    output ffa_pkg::t_ffa_out o_result
);

    ffa_pkg::t_ffa_state r_state, n_state;
    logic [ffa_pkg::ADDR_W-1:0]    r_h, n_h;
    logic [ffa_pkg::SIZE_W-1:0]    r_req, n_req;
    logic [ffa_pkg::SIZE_W-1:0]    r_sz, n_sz;
    logic [ffa_pkg::HEAP_CHUNKS-1:0] r_valid;
    logic                          r_done, n_done;
    ffa_pkg::t_ffa_out             r_res, n_res;

    logic                          ram_we;
    logic [ffa_pkg::ADDR_W-1:0]    ram_addr;
    ffa_pkg::t_ffa_hdr             ram_wdata;
    logic [ffa_pkg::ENTRY_W-1:0]   ram_rdata;

    ffa_pkg::t_ffa_hdr             cur;
    logic [ffa_pkg::WALK_W-1:0]    next_h;
    logic [ffa_pkg::WALK_W-1:0]    rem_h;
    logic [ffa_pkg::WALK_W-1:0]    free_idx;

    ffa_ram #(
        .WIDTH (ffa_pkg::ENTRY_W),
        .DEPTH (ffa_pkg::HEAP_CHUNKS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign cur      = r_valid[r_h] ? ffa_pkg::t_ffa_hdr'(ram_rdata)
                                   : ffa_pkg::ffa_reset_hdr(r_h);
    assign next_h   = {1'b0, r_h} + ffa_pkg::WALK_W'(1) + ffa_pkg::WALK_W'(cur.size);
    assign rem_h    = {1'b0, r_h} + ffa_pkg::WALK_W'(1) + ffa_pkg::WALK_W'(r_req);
    assign free_idx = ffa_pkg::WALK_W'(i_cmd.block_index);
    assign busy     = (r_state != ffa_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::ST_IDLE;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (ram_we) begin
                r_valid[ram_addr] <= 1'b1;
            end
        end
        r_h   <= n_h;
        r_req <= n_req;
        r_sz  <= n_sz;
        r_res <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_h       = r_h;
        n_req     = r_req;
        n_sz      = r_sz;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_addr  = r_h;
        ram_wdata = cur;

        unique case (r_state)
            ffa_pkg::ST_IDLE: begin
                if (start) begin
                    n_req = i_cmd.req_size;
                    if (i_cmd.kind == ffa_pkg::KIND_FREE) begin
                        if (free_idx < ffa_pkg::HEAP_END) begin
                            n_h      = i_cmd.block_index[ffa_pkg::ADDR_W-1:0];
                            ram_addr = i_cmd.block_index[ffa_pkg::ADDR_W-1:0];
                            n_state  = ffa_pkg::ST_FREE;
                        end else begin
                            n_done = 1'b1;
                            n_res  = '0;
                        end
                    end else if (i_cmd.req_size == '0) begin
                        n_done = 1'b1;
                        n_res  = '0;
                    end else begin
                        n_h      = '0;
                        ram_addr = '0;
                        n_state  = ffa_pkg::ST_WALK;
                    end
                end
            end
            ffa_pkg::ST_WALK: begin
                if (cur.used && cur.size == '0) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_state = ffa_pkg::ST_IDLE;
                end else if (!cur.used && cur.size >= r_req) begin
                    // claim the head of this block
                    ram_we         = 1'b1;
                    ram_wdata.size = r_req;
                    ram_wdata.used = 1'b1;
                    n_sz           = cur.size;
                    if (cur.size != r_req && rem_h < ffa_pkg::HEAP_END) begin
                        n_state = ffa_pkg::ST_SPLIT;
                    end else begin
                        n_done            = 1'b1;
                        n_res.ok          = 1'b1;
                        n_res.block_start = ffa_pkg::SIZE_W'(r_h);
                        n_state           = ffa_pkg::ST_IDLE;
                    end
                end else if (next_h >= ffa_pkg::HEAP_END) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_state = ffa_pkg::ST_IDLE;
                end else begin
                    n_h      = next_h[ffa_pkg::ADDR_W-1:0];
                    ram_addr = next_h[ffa_pkg::ADDR_W-1:0];
                end
            end
            ffa_pkg::ST_SPLIT: begin
                ram_we            = 1'b1;
                ram_addr          = rem_h[ffa_pkg::ADDR_W-1:0];
                ram_wdata.size    = r_sz - r_req - ffa_pkg::SIZE_W'(1);
                ram_wdata.used    = 1'b0;
                n_done            = 1'b1;
                n_res.ok          = 1'b1;
                n_res.block_start = ffa_pkg::SIZE_W'(r_h);
                n_state           = ffa_pkg::ST_IDLE;
            end
            ffa_pkg::ST_FREE: begin
                ram_we         = 1'b1;
                ram_wdata.size = cur.size;
                ram_wdata.used = 1'b0;
                n_done         = 1'b1;
                n_res.ok       = 1'b1;
                n_res.block_start = '0;
                n_state        = ffa_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
